/* rtl/svwt_pkg.sv */
package svwt_pkg;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  // Register map
  localparam int          ADDR_W   = 3;
  localparam logic        REG_RATE = 1'b0;   // register index of sample_rate_hz

  // Fixed field and state widths
  localparam int RATE_W  = 18;
  localparam int GAIN_W  = 17;
  localparam int LEVEL_W = 16;
  localparam int SINE_W  = 15;
  localparam int FREQ_W  = 20;
  localparam int OCT_W   = 4;
  localparam int PROD_W  = 48;   // sine * level * gain, Q47 magnitude

  localparam logic [RATE_W-1:0] RATE_RESET   = 18'd48000;
  localparam logic [GAIN_W-1:0] GAIN_ONE     = 17'd65536;
  localparam logic [15:0]       DECAY_Q16    = 16'd64881;
  localparam logic [GAIN_W-1:0] SILENCE_Q16  = 17'd327;
  localparam logic [16:0]       LEVEL_RECIP  = 17'd104858;  // ceil(2^20 / 10)
  localparam logic [63:0]       PI_HALF_Q30  = 64'd1686629713;

  // Controller to datapath commands
  typedef struct packed {
    logic start;      // load a new note, launch the step division
    logic step_load;  // take the division result as phase step
    logic stop;       // apply a stop beat
    logic rom_rd;     // read the sine table at the current phase
    logic mul1;       // sine * level
    logic mul2;       // * release gain
    logic out_load;   // round, fill the output register, advance state
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic rate_zero;
  } dp_stat_t;

  // Octave-zero note frequencies in Q16 Hz
  function automatic logic [FREQ_W-1:0] freq_q16(input logic [3:0] semi);
    logic [FREQ_W-1:0] f;
    unique case (semi)
      4'd0:    f = 20'd535809;
      4'd1:    f = 20'd567670;
      4'd2:    f = 20'd601425;
      4'd3:    f = 20'd637188;
      4'd4:    f = 20'd675077;
      4'd5:    f = 20'd715219;
      4'd6:    f = 20'd757749;
      4'd7:    f = 20'd802807;
      4'd8:    f = 20'd850544;
      4'd9:    f = 20'd901120;
      4'd10:   f = 20'd954703;
      4'd11:   f = 20'd1011473;
      default: f = '0;
    endcase
    return f;
  endfunction

  // Quarter-wave sine magnitude in Q0.15, Taylor series to 13th order in Q30
  function automatic logic [SINE_W-1:0] sine_mag(input int unsigned k,
                                                 input int unsigned tbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        m;
    logic signed [63:0] sum;
    x    = ((64'(k) * PI_HALF_Q30) + (64'd1 << (tbits - 3))) >> (tbits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    m = ($unsigned(sum) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return m[SINE_W-1:0];
  endfunction

endpackage

/* rtl/svwt_div.sv */
// Restoring divider, one quotient bit per cycle, remainder narrow as divisor
module svwt_div #(
  parameter int DVD_W = 48,
  parameter int DEN_W = 19,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    dvd_nxt = {dvd_r[DVD_W-2:0], ge};
  end

  // Iteration count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Dividend shifts out as the quotient shifts in
  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = (cnt_r == '0);
  assign quotient = dvd_r[Q_W-1:0];

endmodule

/* rtl/svwt_dp.sv */
// Voice datapath: note setup, sine table, sample multiply chain, release decay
module svwt_dp import svwt_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat,
  input  logic [RATE_W-1:0]             sample_rate,
  input  logic [6:0]                    in_note,
  input  logic [7:0]                    in_velocity,
  input  logic                          in_allow_tail_off,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_voice_active
);

  localparam int DVD_W   = PHASE_BITS + 16;
  localparam int DEN_W   = RATE_W + 1;
  localparam int QA_W    = SINE_TABLE_BITS - 1;
  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int P1_W    = SINE_W + LEVEL_W;
  localparam int SHIFT   = PROD_W - SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] LIMIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  // Voice state
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [LEVEL_W-1:0]    level_r;
  logic [GAIN_W-1:0]     gain_r;

  // Sample pipeline
  logic                  neg_r;
  logic [SINE_W-1:0]     mag_r;
  logic [P1_W-1:0]       p1_r;
  logic [PROD_W-1:0]     p2_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                  out_active_r;

  // Quarter-wave sine table
  logic [SINE_W-1:0] qtab [QUARTER+1];

  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_qtab
    assign qtab[gi] = sine_mag(gi, SINE_TABLE_BITS);
  end

  // Note setup: octave split, frequency, dividend, level
  logic [OCT_W-1:0]  oct;
  logic [3:0]        semi;
  logic [14:0]       oct_prod;
  logic [DVD_W-1:0]  f_ext;
  logic [DVD_W-1:0]  dividend;
  logic [16:0]       lvl_pre;
  logic [33:0]       lvl_prod;
  logic [LEVEL_W-1:0] level_new;

  always_comb begin
    oct_prod  = 15'({8'd0, in_note} * 15'd171);       // note / 12 for notes below 128
    oct       = oct_prod[14 -: OCT_W];
    semi      = 4'(in_note - 7'(oct) * 7'd12);
    f_ext     = DVD_W'(freq_q16(semi)) << oct;
    dividend  = (f_ext << (PHASE_BITS - 15)) + DVD_W'(sample_rate);
    lvl_pre   = 17'({9'd0, in_velocity} * 17'd384) + 17'd5;
    lvl_prod  = 34'(lvl_pre) * 34'(LEVEL_RECIP);
    level_new = LEVEL_W'(lvl_prod >> 20);
  end

  // Phase step division
  logic                  div_done;
  logic [PHASE_BITS-1:0] quotient;

  svwt_div #(
    .DVD_W (DVD_W),
    .DEN_W (DEN_W),
    .Q_W   (PHASE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.start && !stat.rate_zero),
    .dividend (dividend),
    .divisor  ({sample_rate, 1'b0}),
    .done     (div_done),
    .quotient (quotient)
  );

  assign stat.div_done  = div_done;
  assign stat.rate_zero = (sample_rate == '0);

  // Table address with quarter-wave fold
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [QA_W-1:0]            ka;

  always_comb begin
    idx = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
    if (idx[SINE_TABLE_BITS-2]) begin
      ka = QA_W'(QUARTER) - {1'b0, idx[SINE_TABLE_BITS-3:0]};
    end else begin
      ka = {1'b0, idx[SINE_TABLE_BITS-3:0]};
    end
  end

  // Round, saturate and sign the product; decay the release gain
  logic [GAIN_W-1:0]      gmul;
  logic [PROD_W-1:0]      rnd;
  logic [SAMPLE_BITS-1:0] rmag;
  logic [SAMPLE_BITS-1:0] rsat;
  logic [SAMPLE_BITS-1:0] val;
  logic [32:0]            gprod;
  logic [GAIN_W-1:0]      gdec;
  logic                   silent;

  always_comb begin
    gmul   = (gain_r == '0) ? GAIN_ONE : gain_r;
    rnd    = p2_r + (PROD_W'(1) << (SHIFT - 1));
    rmag   = rnd[PROD_W-1:SHIFT];
    rsat   = (rmag > LIMIT) ? LIMIT : rmag;
    val    = neg_r ? SAMPLE_BITS'(-rsat) : rsat;
    gprod  = 33'(gain_r) * 33'(DECAY_Q16) + 33'd32768;
    gdec   = gprod[32:16];
    silent = (gdec <= SILENCE_Q16);
  end

  // Voice state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= '0;
      level_r <= '0;
      gain_r  <= '0;
    end else begin
      if (cmd.start) begin
        phase_r <= '0;
        gain_r  <= '0;
        level_r <= level_new;
        if (stat.rate_zero) begin
          step_r <= '0;
        end
      end
      if (cmd.step_load) begin
        step_r <= quotient;
      end
      if (cmd.stop) begin
        if (in_allow_tail_off) begin
          if (gain_r == '0) begin
            gain_r <= GAIN_ONE;
          end
        end else begin
          step_r <= '0;
        end
      end
      if (cmd.out_load && (step_r != '0)) begin
        phase_r <= phase_r + step_r;
        if (gain_r != '0) begin
          if (silent) begin
            gain_r <= '0;
            step_r <= '0;
          end else begin
            gain_r <= gdec;
          end
        end
      end
    end
  end

  // Sample pipeline and output register
  always_ff @(posedge clk) begin
    if (cmd.rom_rd) begin
      mag_r <= qtab[ka];
      neg_r <= idx[SINE_TABLE_BITS-1];
    end
    if (cmd.mul1) begin
      p1_r <= P1_W'(mag_r) * P1_W'(level_r);
    end
    if (cmd.mul2) begin
      p2_r <= PROD_W'(p1_r) * PROD_W'(gmul);
    end
    if (cmd.out_load) begin
      if (step_r == '0) begin
        out_sample_r <= '0;
        out_active_r <= 1'b0;
      end else begin
        out_sample_r <= $signed(val);
        out_active_r <= !((gain_r != '0) && silent);
      end
    end
  end

  assign out_sample       = out_sample_r;
  assign out_voice_active = out_active_r;

endmodule

/* rtl/svwt_ctrl.sv */
// Voice controller: accepts beats, sequences the division and the sample chain
module svwt_ctrl import svwt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd_code_t'(in_command))
            CMD_START: begin
              cmd.start = 1'b1;
              if (!stat.rate_zero) begin
                state_nxt = ST_DIV;
              end
            end
            CMD_STOP: begin
              cmd.stop = 1'b1;
            end
            CMD_TICK: begin
              cmd.rom_rd = 1'b1;
              state_nxt  = ST_MUL1;
            end
            CMD_NONE: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.step_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output beat valid
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/sine_voice_with_tail_off.sv */
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// in       | in_valid / in_stall        | in_command, in_note, in_velocity, in_allow_tail_off
// out      | out_valid / out_stall      | out_sample, out_voice_active
// config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready (always high)
//
// A tick beat runs the table read, two multiplies and the round, and waits at the round
// while the output stalls; the next beat is taken the cycle after the result is loaded.
// A start beat holds the input until the bit-serial step divider is done; at a zero
// sample rate, and for stop beats and unused commands, the controller stays idle.
// rst_n is synchronous; it clears voice state and reloads the 48 kHz rate.
// A stalled output holds the controller before the output register is refilled.
module sine_voice_with_tail_off import svwt_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [6:0]                    in_note,
  input  logic [7:0]                    in_velocity,
  input  logic                          in_allow_tail_off,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_voice_active,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [RATE_W-1:0] sample_rate_r;
  logic              rate_sel;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  // Register decode and write
  assign rate_sel = (paddr[ADDR_W-1:2] == REG_RATE);
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= RATE_RESET;
    end else if (psel && penable && pwrite && pready && rate_sel) begin
      sample_rate_r <= pwdata[RATE_W-1:0];
    end
  end

  assign prdata = rate_sel ? 32'(sample_rate_r) : '0;

  svwt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  svwt_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .sample_rate       (sample_rate_r),
    .in_note           (in_note),
    .in_velocity       (in_velocity),
    .in_allow_tail_off (in_allow_tail_off),
    .out_sample        (out_sample),
    .out_voice_active  (out_voice_active)
  );

endmodule

/* rtl/svwt_check.sv */
// Port-level checks on the voice
module svwt_check import svwt_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [1:0]             in_command,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_sample,
  input logic                   out_voice_active,
  input logic                   pready
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_voice_active))
    else $error("stalled output beat changed");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An accepted tick keeps the input side busy through the two multiply states
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_TICK) |=> in_stall ##1 in_stall)
    else $error("input taken while a tick is in flight");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind sine_voice_with_tail_off svwt_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_svwt_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_command       (in_command),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample       (out_sample),
  .out_voice_active (out_voice_active),
  .pready           (pready)
);
